### sv/dpd_pkg.sv
// Package for the debug packet deframer.
// Holds the framing symbols, result codes, phase encoding and shared types.
// No dependencies.
package dpd_pkg;

    localparam int DEFAULT_MAX_LEN = 511;
    localparam int BYTE_W          = 8;
    localparam int KIND_W          = 2;
    localparam int COUNT_OUT_W     = 9;

    localparam logic [BYTE_W-1:0] SYM_STX  = 8'h02;
    localparam logic [BYTE_W-1:0] SYM_ETX  = 8'h03;
    localparam logic [BYTE_W-1:0] SYM_ACK  = 8'h06;
    localparam logic [BYTE_W-1:0] SYM_NAK  = 8'h15;
    localparam logic [BYTE_W-1:0] SYM_NONE = 8'h00;

    localparam logic [BYTE_W-1:0] CH_0 = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9 = 8'h39;
    localparam logic [BYTE_W-1:0] CH_A = 8'h61;
    localparam logic [BYTE_W-1:0] CH_F = 8'h66;

    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GOOD    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BAD     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd3;

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_BODY = 4'b0010,
        PH_HI   = 4'b0100,
        PH_LO   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic                   ok;
        logic [3:0]             value;
    } hex_t;

    // One result beat handed from the parser to the output stage.
    typedef struct packed {
        logic                   vld;
        logic [KIND_W-1:0]      kind;
        logic [BYTE_W-1:0]      data;
        logic [COUNT_OUT_W-1:0] count;
    } result_t;

    // Lower-case hex digit decode; ok is low for anything else.
    function automatic hex_t hex_decode(input logic [BYTE_W-1:0] b);
        hex_t       h;
        logic [7:0] d;
        h = '{ok: 1'b0, value: 4'd0};
        if (b >= CH_0 && b <= CH_9) begin
            d = b - CH_0;
            h = '{ok: 1'b1, value: d[3:0]};
        end else if (b >= CH_A && b <= CH_F) begin
            d = b - CH_A + 8'd10;
            h = '{ok: 1'b1, value: d[3:0]};
        end
        return h;
    endfunction

endpackage

### sv/dpd_parser.sv
// Input register and framing state machine of the debug packet deframer.
// Depends on dpd_pkg.
module dpd_parser #(
    parameter int MAX_LEN = dpd_pkg::DEFAULT_MAX_LEN
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [dpd_pkg::BYTE_W-1:0] s_rx_byte,
    input  logic                       slot_ok,
    output dpd_pkg::result_t           res
);
    import dpd_pkg::*;

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [3:0]        nib_reg, nib_next;
    logic              fire;
    hex_t              hex;
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;
    logic [COUNT_OUT_W-1:0]       count_out;

    assign fire    = in_valid_reg && slot_ok;
    assign s_ready = !in_valid_reg || slot_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    assign hex       = hex_decode(in_byte_reg);
    assign count_ext = {{COUNT_OUT_W{1'b0}}, count_reg};
    assign count_out = count_ext[COUNT_OUT_W-1:0];

    always_comb begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        nib_next   = nib_reg;
        res        = '{vld: 1'b0, kind: KIND_ERROR, data: SYM_NONE, count: count_out};
        unique case (phase_reg)
            PH_HUNT: begin
                if (in_byte_reg == SYM_STX) begin
                    sum_next   = '0;
                    count_next = '0;
                    nib_next   = '0;
                    phase_next = PH_BODY;
                end
            end
            PH_BODY: begin
                if (in_byte_reg == SYM_ETX) begin
                    phase_next = PH_HI;
                end else if (in_byte_reg == SYM_STX || count_reg >= CNT_MAX) begin
                    phase_next = PH_HUNT;
                    res.vld    = 1'b1;
                end else begin
                    res.vld    = 1'b1;
                    res.kind   = KIND_PAYLOAD;
                    res.data   = in_byte_reg;
                    sum_next   = sum_reg + in_byte_reg;
                    count_next = count_reg + 1'b1;
                end
            end
            PH_HI: begin
                if (!hex.ok) begin
                    phase_next = PH_HUNT;
                    res.vld    = 1'b1;
                end else begin
                    nib_next   = hex.value;
                    phase_next = PH_LO;
                end
            end
            PH_LO: begin
                phase_next = PH_HUNT;
                res.vld    = 1'b1;
                if (hex.ok && {nib_reg, hex.value} == sum_reg) begin
                    res.kind = KIND_GOOD;
                    res.data = SYM_ACK;
                end else if (hex.ok) begin
                    res.kind = KIND_BAD;
                    res.data = SYM_NAK;
                end
            end
            default: begin
                phase_next = PH_HUNT;
            end
        endcase
        // Nothing is emitted unless the buffered beat is actually consumed.
        res.vld = res.vld && fire;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            sum_reg   <= '0;
            count_reg <= '0;
            nib_reg   <= '0;
        end else if (fire) begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
            nib_reg   <= nib_next;
        end
    end

endmodule

### sv/dpd_out_stage.sv
// Result register of the debug packet deframer; drives the m_ channel.
// Depends on dpd_pkg.
module dpd_out_stage (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  dpd_pkg::result_t                res,
    output logic                            slot_ok,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [dpd_pkg::KIND_W-1:0]      m_kind,
    output logic [dpd_pkg::BYTE_W-1:0]      m_data_byte,
    output logic [dpd_pkg::COUNT_OUT_W-1:0] m_byte_count
);
    import dpd_pkg::*;

    logic              valid_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [BYTE_W-1:0] data_reg;
    logic [COUNT_OUT_W-1:0] count_reg;

    // The register can take a new beat when empty or when its beat leaves now.
    assign slot_ok = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res.vld) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.vld) begin
            kind_reg  <= res.kind;
            data_reg  <= res.data;
            count_reg <= res.count;
        end
    end

    assign m_valid      = valid_reg;
    assign m_kind       = kind_reg;
    assign m_data_byte  = data_reg;
    assign m_byte_count = count_reg;

endmodule

### sv/debug_packet_deframer.sv
// Debug packet deframer: one received serial byte per s_ beat, at most one
// result beat out. Bytes are held in an input register, combinational framing
// logic decides the result, and a result register drives the m_ channel, so a
// byte can be taken every cycle while m_ready does not stall the output. The
// per-byte state update and checksum compare sit between the two registers.
// Hunting drops all bytes until STX; payload bytes come out as kind 0, and a
// packet ends with a good (ACK), bad (NAK) or protocol-error result.
module debug_packet_deframer #(
    parameter int MAX_LEN = dpd_pkg::DEFAULT_MAX_LEN
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [dpd_pkg::BYTE_W-1:0]      s_rx_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [dpd_pkg::KIND_W-1:0]      m_kind,
    output logic [dpd_pkg::BYTE_W-1:0]      m_data_byte,
    output logic [dpd_pkg::COUNT_OUT_W-1:0] m_byte_count
);
    import dpd_pkg::*;

    result_t res;
    logic    slot_ok;

    dpd_parser #(
        .MAX_LEN(MAX_LEN)
    ) u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_rx_byte(s_rx_byte),
        .slot_ok  (slot_ok),
        .res      (res)
    );

    dpd_out_stage u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .res         (res),
        .slot_ok     (slot_ok),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_data_byte (m_data_byte),
        .m_byte_count(m_byte_count)
    );

endmodule

### sv/dpd_checker.sv
// Port-level checks for the debug packet deframer, bound to the top level.
// Depends on dpd_pkg and debug_packet_deframer.
module dpd_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [dpd_pkg::KIND_W-1:0]      m_kind,
    input logic [dpd_pkg::BYTE_W-1:0]      m_data_byte,
    input logic [dpd_pkg::COUNT_OUT_W-1:0] m_byte_count
);
    import dpd_pkg::*;

    // A stalled result beat must hold.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_data_byte)
            && $stable(m_byte_count))
        else $error("result beat changed while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_GOOD |-> m_data_byte == SYM_ACK)
        else $error("good packet without ACK reply");

    a_nak: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_BAD |-> m_data_byte == SYM_NAK)
        else $error("bad packet without NAK reply");

    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_ERROR |-> m_data_byte == SYM_NONE)
        else $error("protocol error with nonzero data");

endmodule

bind debug_packet_deframer dpd_checker u_dpd_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_kind      (m_kind),
    .m_data_byte (m_data_byte),
    .m_byte_count(m_byte_count)
);
